// ===== src/pidvi_pkg.sv =====
package pidvi_pkg;

  // Field and datapath widths
  localparam int AngleW = 16;
  localparam int ErrW   = AngleW + 1;   // measured minus target
  localparam int DErrW  = ErrW + 1;     // error minus previous error
  localparam int MagW   = 16;           // |error| never exceeds 65535
  localparam int GainW  = 16;
  localparam int SepW   = 16;
  localparam int RecipW = 24;
  localparam int SumW   = 32;
  localparam int WeightW = RecipW + 1;  // Q1.24, up to 1.0 inclusive
  localparam int DriveW = 24;
  localparam int MulAW  = 33;
  localparam int MulBW  = 26;
  localparam int ProdW  = MulAW + MulBW;
  localparam int TermW  = GainW + SumW; // ki times error sum
  localparam int AccW   = 50;
  localparam int ShiftW = AccW - 8;     // accumulator after the rounding shift

  // Register map
  localparam int RegNum  = 6;
  localparam int RegIdxW = 3;
  localparam int AddrW   = RegIdxW + 2;
  localparam int DataW   = 32;
  localparam logic [RegIdxW-1:0] REG_KP    = 3'd0;
  localparam logic [RegIdxW-1:0] REG_KI    = 3'd1;
  localparam logic [RegIdxW-1:0] REG_KD    = 3'd2;
  localparam logic [RegIdxW-1:0] REG_LOW   = 3'd3;
  localparam logic [RegIdxW-1:0] REG_HIGH  = 3'd4;
  localparam logic [RegIdxW-1:0] REG_RECIP = 3'd5;

  localparam logic [SepW-1:0]   SEP_LOW_RST   = 16'd3840;
  localparam logic [SepW-1:0]   SEP_HIGH_RST  = 16'd7680;
  localparam logic [RecipW-1:0] SEP_RECIP_RST = 24'd4369;

  localparam logic [WeightW-1:0] W_ONE = 25'h100_0000;
  localparam logic signed [ShiftW-1:0] DRIVE_MAX = ShiftW'(64'sd8388607);
  localparam logic signed [ShiftW-1:0] DRIVE_MIN = ShiftW'(-64'sd8388607);
  localparam logic signed [AccW-1:0]   ROUND_HALF = AccW'(64'sd128);

  // Microcode
  localparam int StepNum = 9;
  localparam int PcW     = $clog2(StepNum);
  typedef logic [PcW-1:0] pc_t;

  typedef enum logic [2:0] {
    MS_NONE,
    MS_KP_E,
    MS_KD_DE,
    MS_KI_SUM,
    MS_DIFF_RECIP,
    MS_HI_W,
    MS_LO_W
  } mul_sel_e;

  typedef enum logic [1:0] {
    AC_NONE,
    AC_LOAD,
    AC_ADD,
    AC_ADD_SH
  } acc_op_e;

  typedef enum logic {
    JC_NONE,
    JC_NOT_MID
  } jmp_cond_e;

  typedef struct packed {
    mul_sel_e  mul_sel;
    acc_op_e   acc_op;
    logic      upd;      // error sum, previous error and weight class
    logic      t_load;   // keep ki*sum
    logic      w_load;   // keep clamped ramp weight
    jmp_cond_e jmp_cond;
    pc_t       jmp_tgt;
    logic      last;     // round, saturate and present the word
  } ucode_t;

  localparam pc_t STEP_HI_W = pc_t'(5);

  localparam ucode_t UC_NOP = '{
    mul_sel:  MS_NONE,
    acc_op:   AC_NONE,
    upd:      1'b0,
    t_load:   1'b0,
    w_load:   1'b0,
    jmp_cond: JC_NONE,
    jmp_tgt:  '0,
    last:     1'b0
  };

  // Control store: product of step n lands in the product register for step n+1
  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    w = UC_NOP;
    case (pc)
      pc_t'(0): begin
        w.upd     = 1'b1;
        w.mul_sel = MS_KP_E;
      end
      pc_t'(1): begin
        w.mul_sel = MS_KD_DE;
        w.acc_op  = AC_LOAD;
      end
      pc_t'(2): begin
        w.mul_sel = MS_KI_SUM;
        w.acc_op  = AC_ADD;
      end
      pc_t'(3): begin
        w.mul_sel  = MS_DIFF_RECIP;
        w.t_load   = 1'b1;
        w.jmp_cond = JC_NOT_MID;
        w.jmp_tgt  = STEP_HI_W;
      end
      pc_t'(4): begin
        w.w_load = 1'b1;
      end
      pc_t'(5): begin
        w.mul_sel = MS_HI_W;
      end
      pc_t'(6): begin
        w.mul_sel = MS_LO_W;
        w.acc_op  = AC_ADD;
      end
      pc_t'(7): begin
        w.acc_op = AC_ADD_SH;
      end
      pc_t'(8): begin
        w.last = 1'b1;
      end
      default: begin
        w = UC_NOP;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== src/pidvi_seq.sv =====
module pidvi_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,     // word accepted on the input channel
  input  logic              mid_i,       // error lies on the weight ramp
  input  logic              out_hold_i,  // output register full and stalled
  output logic              busy_o,
  output pidvi_pkg::ucode_t ctrl_o
);

  logic              running_q, running_d;
  pidvi_pkg::pc_t    pc_q, pc_d;
  pidvi_pkg::ucode_t word;

  assign word   = pidvi_pkg::ucode_rom(pc_q);
  assign ctrl_o = running_q ? word : pidvi_pkg::UC_NOP;
  assign busy_o = running_q;

  // Step counter with conditional jump and hold on the final step
  always_comb begin
    running_d = running_q;
    pc_d      = pc_q;
    if (!running_q) begin
      if (start_i) begin
        running_d = 1'b1;
        pc_d      = '0;
      end
    end else if (word.last) begin
      if (!out_hold_i) begin
        running_d = 1'b0;
        pc_d      = '0;
      end
    end else if (word.jmp_cond == pidvi_pkg::JC_NOT_MID && !mid_i) begin
      pc_d = word.jmp_tgt;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      pc_q      <= '0;
    end else begin
      running_q <= running_d;
      pc_q      <= pc_d;
    end
  end

endmodule

// ===== src/pid_variable_integral.sv =====
// PID with variable-speed integral, one shared 33x26 multiplier run by a microcode store.
// The weight-load step runs only when the error is on the weight ramp and is skipped
// otherwise; one word in flight, so the next word is taken after the drive word is loaded.
// The step count is set by the six products that share the one multiplier.
// Reset (async, active low) clears the loop state and gains and loads the default
// thresholds; the output register comes up empty.
module pid_variable_integral (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [pidvi_pkg::AngleW-1:0]  actual_angle_i,
  input  logic signed [pidvi_pkg::AngleW-1:0]  target_angle_i,
  // output channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [pidvi_pkg::DriveW-1:0]  drive_o,
  // register port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic        [pidvi_pkg::AddrW-1:0]   paddr,
  input  logic        [pidvi_pkg::DataW-1:0]   pwdata,
  output logic        [pidvi_pkg::DataW-1:0]   prdata,
  output logic                                 pready
);

  // Configuration registers
  logic signed [pidvi_pkg::GainW-1:0]  kp_q, ki_q, kd_q;
  logic        [pidvi_pkg::SepW-1:0]   low_q, high_q;
  logic        [pidvi_pkg::RecipW-1:0] recip_q;

  // Loop state
  logic signed [pidvi_pkg::AngleW-1:0] last_q;
  logic signed [pidvi_pkg::ErrW-1:0]   prev_q;
  logic signed [pidvi_pkg::SumW-1:0]   sum_q;

  // Working registers
  logic signed [pidvi_pkg::ErrW-1:0]    e_q;
  logic signed [pidvi_pkg::AngleW-1:0]  tgt_q;
  logic signed [pidvi_pkg::DErrW-1:0]   de_q;
  logic        [pidvi_pkg::MagW-1:0]    mag_q;
  logic                                 mid_q;
  logic        [pidvi_pkg::WeightW-1:0] w_q;
  logic signed [pidvi_pkg::TermW-1:0]   t_q;
  logic signed [pidvi_pkg::ProdW-1:0]   prod_q;
  logic signed [pidvi_pkg::AccW-1:0]    acc_q;
  logic signed [pidvi_pkg::DriveW-1:0]  drive_q;
  logic                                 out_valid_q;

  logic              busy;
  logic              in_acc;
  logic              out_hold;
  logic              out_load;
  logic              cfg_wr;
  pidvi_pkg::ucode_t ctrl;

  assign in_acc     = in_valid_i && !busy;
  assign in_stall_o = busy;
  assign out_hold   = out_valid_q && out_stall_i;
  assign out_load   = ctrl.last && !out_hold;
  assign out_valid_o = out_valid_q;
  assign drive_o    = drive_q;

  pidvi_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_acc),
    .mid_i      (mid_q),
    .out_hold_i (out_hold),
    .busy_o     (busy),
    .ctrl_o     (ctrl)
  );

  // Register port
  logic [pidvi_pkg::RegIdxW-1:0] reg_idx;
  assign reg_idx = paddr[pidvi_pkg::AddrW-1:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    case (reg_idx)
      pidvi_pkg::REG_KP:    prdata = pidvi_pkg::DataW'(unsigned'(kp_q));
      pidvi_pkg::REG_KI:    prdata = pidvi_pkg::DataW'(unsigned'(ki_q));
      pidvi_pkg::REG_KD:    prdata = pidvi_pkg::DataW'(unsigned'(kd_q));
      pidvi_pkg::REG_LOW:   prdata = pidvi_pkg::DataW'(low_q);
      pidvi_pkg::REG_HIGH:  prdata = pidvi_pkg::DataW'(high_q);
      pidvi_pkg::REG_RECIP: prdata = pidvi_pkg::DataW'(recip_q);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q    <= '0;
      ki_q    <= '0;
      kd_q    <= '0;
      low_q   <= pidvi_pkg::SEP_LOW_RST;
      high_q  <= pidvi_pkg::SEP_HIGH_RST;
      recip_q <= pidvi_pkg::SEP_RECIP_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        pidvi_pkg::REG_KP:    kp_q    <= signed'(pwdata[pidvi_pkg::GainW-1:0]);
        pidvi_pkg::REG_KI:    ki_q    <= signed'(pwdata[pidvi_pkg::GainW-1:0]);
        pidvi_pkg::REG_KD:    kd_q    <= signed'(pwdata[pidvi_pkg::GainW-1:0]);
        pidvi_pkg::REG_LOW:   low_q   <= pwdata[pidvi_pkg::SepW-1:0];
        pidvi_pkg::REG_HIGH:  high_q  <= pwdata[pidvi_pkg::SepW-1:0];
        pidvi_pkg::REG_RECIP: recip_q <= pwdata[pidvi_pkg::RecipW-1:0];
        default: ;
      endcase
    end
  end

  // Update step: clear on target change, saturating sum, error difference, weight class
  logic                                 clr;
  logic signed [pidvi_pkg::SumW-1:0]    sum_base;
  logic signed [pidvi_pkg::ErrW-1:0]    prev_base;
  logic signed [pidvi_pkg::SumW:0]      sum_wide;
  logic signed [pidvi_pkg::SumW-1:0]    sum_next;
  logic signed [pidvi_pkg::ErrW-1:0]    e_neg;
  logic        [pidvi_pkg::MagW-1:0]    mag;

  assign clr       = tgt_q != last_q;
  assign sum_base  = clr ? '0 : sum_q;
  assign prev_base = clr ? '0 : prev_q;
  assign sum_wide  = {sum_base[pidvi_pkg::SumW-1], sum_base}
                   + (pidvi_pkg::SumW+1)'(e_q);
  assign e_neg     = -e_q;
  assign mag       = e_q[pidvi_pkg::ErrW-1] ? e_neg[pidvi_pkg::MagW-1:0]
                                            : e_q[pidvi_pkg::MagW-1:0];

  always_comb begin
    if (sum_wide[pidvi_pkg::SumW] != sum_wide[pidvi_pkg::SumW-1]) begin
      sum_next = sum_wide[pidvi_pkg::SumW] ? {1'b1, {(pidvi_pkg::SumW-1){1'b0}}}
                                           : {1'b0, {(pidvi_pkg::SumW-1){1'b1}}};
    end else begin
      sum_next = sum_wide[pidvi_pkg::SumW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      prev_q <= '0;
      sum_q  <= '0;
    end else if (ctrl.upd) begin
      last_q <= tgt_q;
      prev_q <= e_q;
      sum_q  <= sum_next;
    end
  end

  // Shared multiplier operand select
  logic signed [pidvi_pkg::MulAW-1:0] mul_a;
  logic signed [pidvi_pkg::MulBW-1:0] mul_b;
  logic signed [pidvi_pkg::ProdW-1:0] prod_d;
  logic        [pidvi_pkg::SepW:0]    ramp_diff;

  assign ramp_diff = {1'b0, high_q} - {1'b0, mag_q};

  always_comb begin
    case (ctrl.mul_sel)
      pidvi_pkg::MS_KP_E: begin
        mul_a = pidvi_pkg::MulAW'(e_q);
        mul_b = pidvi_pkg::MulBW'(kp_q);
      end
      pidvi_pkg::MS_KD_DE: begin
        mul_a = pidvi_pkg::MulAW'(de_q);
        mul_b = pidvi_pkg::MulBW'(kd_q);
      end
      pidvi_pkg::MS_KI_SUM: begin
        mul_a = pidvi_pkg::MulAW'(sum_q);
        mul_b = pidvi_pkg::MulBW'(ki_q);
      end
      pidvi_pkg::MS_DIFF_RECIP: begin
        mul_a = signed'(pidvi_pkg::MulAW'(ramp_diff));
        mul_b = signed'(pidvi_pkg::MulBW'(recip_q));
      end
      // upper half of ki*sum keeps its sign
      pidvi_pkg::MS_HI_W: begin
        mul_a = pidvi_pkg::MulAW'(signed'(t_q[pidvi_pkg::TermW-1:24]));
        mul_b = signed'(pidvi_pkg::MulBW'(w_q));
      end
      pidvi_pkg::MS_LO_W: begin
        mul_a = signed'(pidvi_pkg::MulAW'(t_q[23:0]));
        mul_b = signed'(pidvi_pkg::MulBW'(w_q));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // Working datapath registers
  logic signed [pidvi_pkg::AccW-1:0] prod_acc;
  logic signed [pidvi_pkg::AccW-1:0] prod_sh;

  assign prod_acc = prod_q[pidvi_pkg::AccW-1:0];
  assign prod_sh  = signed'(pidvi_pkg::AccW'(prod_q[48:24]));

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;

    if (in_acc) begin
      e_q   <= pidvi_pkg::ErrW'(actual_angle_i) - pidvi_pkg::ErrW'(target_angle_i);
      tgt_q <= target_angle_i;
    end

    if (ctrl.upd) begin
      de_q  <= pidvi_pkg::DErrW'(e_q) - pidvi_pkg::DErrW'(prev_base);
      mag_q <= mag;
      if (mag >= high_q) begin
        w_q   <= '0;
        mid_q <= 1'b0;
      end else if (mag <= low_q) begin
        w_q   <= pidvi_pkg::W_ONE;
        mid_q <= 1'b0;
      end else begin
        mid_q <= 1'b1;
      end
    end

    if (ctrl.t_load) begin
      t_q <= prod_q[pidvi_pkg::TermW-1:0];
    end

    // ramp weight, capped at 1.0
    if (ctrl.w_load) begin
      if (prod_q > signed'(pidvi_pkg::ProdW'(pidvi_pkg::W_ONE))) begin
        w_q <= pidvi_pkg::W_ONE;
      end else begin
        w_q <= prod_q[pidvi_pkg::WeightW-1:0];
      end
    end

    case (ctrl.acc_op)
      pidvi_pkg::AC_LOAD:   acc_q <= prod_acc;
      pidvi_pkg::AC_ADD:    acc_q <= acc_q + prod_acc;
      pidvi_pkg::AC_ADD_SH: acc_q <= acc_q + prod_sh;
      default: ;
    endcase
  end

  // Round half up, floor shift, saturate to the drive range
  logic signed [pidvi_pkg::AccW-1:0]   acc_rnd;
  logic signed [pidvi_pkg::ShiftW-1:0] acc_shr;
  logic signed [pidvi_pkg::DriveW-1:0] drive_d;

  assign acc_rnd = acc_q + pidvi_pkg::ROUND_HALF;
  assign acc_shr = acc_rnd[pidvi_pkg::AccW-1:8];

  always_comb begin
    if (acc_shr > pidvi_pkg::DRIVE_MAX) begin
      drive_d = pidvi_pkg::DRIVE_MAX[pidvi_pkg::DriveW-1:0];
    end else if (acc_shr < pidvi_pkg::DRIVE_MIN) begin
      drive_d = pidvi_pkg::DRIVE_MIN[pidvi_pkg::DriveW-1:0];
    end else begin
      drive_d = acc_shr[pidvi_pkg::DriveW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      drive_q <= drive_d;
    end
  end

  // Output word valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

endmodule
